@@ rtl/dled_pkg.sv @@
// shared types and constants for the dle stx/etx deframer with xor lrc check
// no dependencies; imported by every module of the block
`default_nettype none
package dled_pkg;

  localparam int unsigned LEN_BITS_DEF = 12;
  localparam int unsigned CFG_W        = 12;

  localparam logic [CFG_W-1:0] MAX_PAYLOAD_RST = 12'd256;

  localparam logic [7:0] DLE = 8'h10;
  localparam logic [7:0] STX = 8'h02;
  localparam logic [7:0] ETX = 8'h03;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_HDR_ERR   = 3'd1;
  localparam logic [2:0] ST_NO_TRLR   = 3'd2;
  localparam logic [2:0] ST_ESC_ERR   = 3'd3;
  localparam logic [2:0] ST_LRC_ERR   = 3'd4;
  localparam logic [2:0] ST_TOO_SHORT = 3'd5;
  localparam logic [2:0] ST_TOO_LONG  = 3'd6;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_last;
  } item_t;

  typedef struct packed {
    logic       vld;
    logic       kind;
    logic [7:0] data;
    logic [2:0] status;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/dled_in_if.sv @@
// input channel: raw received bytes with buffer end flag
// depends on nothing
`default_nettype none
interface dled_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_last;

  modport source (output valid, output rx_byte, output buffer_last, input ready);
  modport sink (input valid, input rx_byte, input buffer_last, output ready);
endinterface
`default_nettype wire

@@ rtl/dled_out_if.sv @@
// result channel: payload bytes and frame status
// depends on nothing
`default_nettype none
interface dled_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data;
  logic [2:0] status;

  modport source (output valid, output kind, output data, output status, input ready);
  modport sink (input valid, input kind, input data, input status, output ready);
endinterface
`default_nettype wire

@@ rtl/dled_cfg_if.sv @@
// configuration write channel for the max_payload register
// depends on nothing
`default_nettype none
interface dled_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] max_payload;

  modport source (output valid, output max_payload, input ready);
  modport sink (input valid, input max_payload, output ready);
endinterface
`default_nettype wire

@@ rtl/dle_stx_etx_deframer_lrc_unit.sv @@
// a byte is held in the input register once accepted; its result is loaded into the result
// register when the frame state advances, and is offered on out_ch from there
// throughput: one byte per cycle while the result register is free or read, set by the
// frame state update between the input register and the result register; a full result
// register that is not read holds the input, also for bytes that give no result
// reset: synchronous active-low rst_n clears the valid flags and the frame state; max_payload returns to 256
`default_nettype none
module dle_stx_etx_deframer_lrc_unit
  import dled_pkg::*;
#(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  wire clk,
  input  wire rst_n,
  dled_in_if.sink     in_ch,
  dled_out_if.source  out_ch,
  dled_cfg_if.sink    cfg_ch
);

  logic [CFG_W-1:0] max_payload_r;
  logic             ivld;
  item_t            item;
  res_t             res;
  logic             ofree;
  logic             advance;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_ch.valid) begin
      max_payload_r <= cfg_ch.max_payload;
    end
  end

  assign advance = ivld && ofree;

  dled_ibuf u_ibuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .vld     (ivld),
    .item    (item)
  );

  dled_fsm #(
    .LEN_BITS (LEN_BITS)
  ) u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .item        (item),
    .max_payload (max_payload_r),
    .res         (res)
  );

  dled_obuf u_obuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (advance && res.vld),
    .res    (res),
    .free   (ofree),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

@@ rtl/dled_ibuf.sv @@
// input register stage of the deframer
// depends on dled_pkg and dled_in_if
`default_nettype none
module dled_ibuf
  import dled_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  dled_in_if.sink in_ch,
  input  wire   advance,
  output logic  vld,
  output item_t item
);

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  take;

  assign in_ch.ready = !vld_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.rx_byte     <= in_ch.rx_byte;
      item_r.buffer_last <= in_ch.buffer_last;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule
`default_nettype wire

@@ rtl/dled_fsm.sv @@
// frame state machine: unstuffing, lrc, length check and status
// depends on dled_pkg
`default_nettype none
module dled_fsm
  import dled_pkg::*;
#(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              en,
  input  item_t            item,
  input  wire  [CFG_W-1:0] max_payload,
  output res_t             res
);

  localparam int unsigned CW = (LEN_BITS > CFG_W) ? LEN_BITS : CFG_W;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2,
    PH_ESC  = 2'd3
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [7:0]          held_byte_r, held_byte_nxt;
  logic                held_valid_r, held_valid_nxt;
  logic [7:0]          lrc_acc_r, lrc_acc_nxt;
  logic [LEN_BITS-1:0] byte_count_r, byte_count_nxt;
  logic                junk_r, junk_nxt;

  logic [CW-1:0] cap;
  logic [CW-1:0] mp_ext;
  logic [CW-1:0] lim;
  logic          full;
  logic [7:0]    b;

  assign b      = item.rx_byte;
  assign cap    = CW'({LEN_BITS{1'b1}});
  assign mp_ext = CW'(max_payload);
  assign lim    = (mp_ext < cap) ? mp_ext : cap;
  assign full   = CW'(byte_count_r) >= lim;

  always_comb begin
    phase_nxt      = phase_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    lrc_acc_nxt    = lrc_acc_r;
    byte_count_nxt = byte_count_r;
    junk_nxt       = junk_r;
    res            = '0;

    case (phase_r)
      PH_IDLE: begin
        if (b == DLE) begin
          phase_nxt = PH_HDR;
        end else if (!junk_r) begin
          junk_nxt   = 1'b1;
          res.vld    = 1'b1;
          res.kind   = KIND_STATUS;
          res.status = ST_HDR_ERR;
        end
      end
      PH_HDR: begin
        if (b == STX) begin
          phase_nxt      = PH_BODY;
          held_byte_nxt  = '0;
          held_valid_nxt = 1'b0;
          lrc_acc_nxt    = '0;
          byte_count_nxt = '0;
          junk_nxt       = 1'b0;
        end else begin
          if (b != DLE) begin
            phase_nxt = PH_IDLE;
          end
          if (!junk_r) begin
            junk_nxt   = 1'b1;
            res.vld    = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_HDR_ERR;
          end
        end
      end
      PH_BODY, PH_ESC: begin
        if (phase_r == PH_BODY && b == DLE) begin
          phase_nxt = PH_ESC;
        end else if (phase_r == PH_BODY || b == DLE) begin
          // payload byte, held back one position for the lrc
          phase_nxt = PH_BODY;
          if (held_valid_r && full) begin
            phase_nxt      = PH_IDLE;
            held_byte_nxt  = '0;
            held_valid_nxt = 1'b0;
            lrc_acc_nxt    = '0;
            byte_count_nxt = '0;
            res.vld        = 1'b1;
            res.kind       = KIND_STATUS;
            res.status     = ST_TOO_LONG;
          end else begin
            if (held_valid_r) begin
              res.vld        = 1'b1;
              res.kind       = KIND_DATA;
              res.data       = held_byte_r;
              byte_count_nxt = byte_count_r + LEN_BITS'(1);
            end
            lrc_acc_nxt    = lrc_acc_r ^ b;
            held_byte_nxt  = b;
            held_valid_nxt = 1'b1;
          end
        end else if (b == STX) begin
          phase_nxt      = PH_BODY;
          held_byte_nxt  = '0;
          held_valid_nxt = 1'b0;
          lrc_acc_nxt    = '0;
          byte_count_nxt = '0;
          junk_nxt       = 1'b0;
        end else begin
          phase_nxt      = PH_IDLE;
          held_byte_nxt  = '0;
          held_valid_nxt = 1'b0;
          lrc_acc_nxt    = '0;
          byte_count_nxt = '0;
          res.vld        = 1'b1;
          res.kind       = KIND_STATUS;
          if (b != ETX) begin
            res.status = ST_ESC_ERR;
          end else if (!held_valid_r || byte_count_r == '0) begin
            res.status = ST_TOO_SHORT;
          end else if (lrc_acc_r != '0) begin
            res.status = ST_LRC_ERR;
          end else begin
            res.status = ST_OK;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // buffer end overrides
    if (item.buffer_last) begin
      if (phase_nxt == PH_BODY || phase_nxt == PH_ESC) begin
        phase_nxt      = PH_IDLE;
        held_byte_nxt  = '0;
        held_valid_nxt = 1'b0;
        lrc_acc_nxt    = '0;
        byte_count_nxt = '0;
        res            = '0;
        res.vld        = 1'b1;
        res.kind       = KIND_STATUS;
        res.status     = ST_NO_TRLR;
      end else if (phase_nxt == PH_HDR) begin
        phase_nxt = PH_IDLE;
        if (!res.vld && !junk_nxt) begin
          res.vld    = 1'b1;
          res.kind   = KIND_STATUS;
          res.status = ST_HDR_ERR;
        end
      end
      junk_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      lrc_acc_r    <= '0;
      byte_count_r <= '0;
      junk_r       <= 1'b0;
    end else if (en) begin
      phase_r      <= phase_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      lrc_acc_r    <= lrc_acc_nxt;
      byte_count_r <= byte_count_nxt;
      junk_r       <= junk_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    !held_valid_r |-> byte_count_r == '0)
    else $error("byte count nonzero without held byte");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE || phase_r == PH_HDR) |-> (!held_valid_r && lrc_acc_r == '0))
    else $error("frame state left over outside a frame");

  a_data_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.vld && res.kind == KIND_DATA) |=>
      byte_count_r == $past(byte_count_r) + LEN_BITS'(1))
    else $error("payload byte emitted without count update");

  a_data_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.vld && res.kind == KIND_DATA) |=> phase_r == PH_BODY)
    else $error("payload byte emitted outside body phase");
`endif

endmodule
`default_nettype wire

@@ rtl/dled_obuf.sv @@
// result register stage of the deframer
// depends on dled_pkg and dled_out_if
`default_nettype none
module dled_obuf
  import dled_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  load,
  input  res_t res,
  output logic free,
  dled_out_if.source out_ch
);

  logic       vld_r, vld_nxt;
  logic       kind_r;
  logic [7:0] data_r;
  logic [2:0] status_r;

  assign free = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= res.kind;
      data_r   <= res.data;
      status_r <= res.status;
    end
  end

  assign out_ch.valid  = vld_r;
  assign out_ch.kind   = kind_r;
  assign out_ch.data   = data_r;
  assign out_ch.status = status_r;

endmodule
`default_nettype wire

@@ tb/dled_check.sv @@
`timescale 1ns / 1ps
// result checker for the dle stx/etx deframer: watches the input, config and result
// channels, predicts each transaction's results and compares them in order
// depends on dled_pkg
module dled_check
  import dled_pkg::*;
#(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  input  logic             in_buffer_last,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_kind,
  input  logic [7:0]       out_data,
  input  logic [2:0]       out_status,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_max_payload,
  output int               fail_count,
  output int               pending,
  output int               bytes_seen,
  output int               payload_seen,
  output int               status_count,
  output logic [6:0]       status_seen
);

  typedef enum logic [1:0] {PH_IDLE, PH_HDR, PH_BODY, PH_ESC} rx_phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [2:0] status;
  } deframed_t;

  rx_phase_t           phase;
  logic [7:0]          held_byte;
  logic                held_valid;
  logic [7:0]          lrc_acc;
  logic [LEN_BITS-1:0] payload_count;
  logic                junk_reported;
  logic [CFG_W-1:0]    max_payload;
  deframed_t           expected_results[$];
  deframed_t           want;

  function automatic deframed_t status_of(input logic [2:0] st);
    deframed_t r;
    r.kind   = KIND_STATUS;
    r.data   = '0;
    r.status = st;
    return r;
  endfunction

  function automatic void clear_frame();
    held_byte     = '0;
    held_valid    = 1'b0;
    lrc_acc       = '0;
    payload_count = '0;
  endfunction

  function automatic void start_frame();
    clear_frame();
    phase         = PH_BODY;
    junk_reported = 1'b0;
  endfunction

  // only the first junk byte outside a frame is reported
  function automatic void flag_junk(inout logic hit, inout deframed_t r);
    if (!junk_reported) begin
      junk_reported = 1'b1;
      hit           = 1'b1;
      r             = status_of(ST_HDR_ERR);
    end
  endfunction

  // one byte is held back so the trailing lrc byte never shows up as payload
  function automatic void take_payload(input logic [7:0] b, inout logic hit,
                                       inout deframed_t r);
    int unsigned cap;
    int unsigned lim;
    cap   = (1 << LEN_BITS) - 1;
    lim   = (max_payload < cap) ? max_payload : cap;
    phase = PH_BODY;
    if (held_valid && payload_count >= lim) begin
      clear_frame();
      phase = PH_IDLE;
      hit   = 1'b1;
      r     = status_of(ST_TOO_LONG);
    end else begin
      if (held_valid) begin
        hit           = 1'b1;
        r.kind        = KIND_DATA;
        r.data        = held_byte;
        r.status      = ST_OK;
        payload_count = payload_count + 1'b1;
      end
      lrc_acc    = lrc_acc ^ b;
      held_byte  = b;
      held_valid = 1'b1;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic last);
    logic      hit;
    deframed_t r;
    hit = 1'b0;
    r   = '0;
    case (phase)
      PH_IDLE: begin
        if (b == DLE) phase = PH_HDR;
        else flag_junk(hit, r);
      end
      PH_HDR: begin
        if (b == STX) begin
          start_frame();
        end else begin
          if (b != DLE) phase = PH_IDLE;
          flag_junk(hit, r);
        end
      end
      PH_BODY: begin
        if (b == DLE) phase = PH_ESC;
        else take_payload(b, hit, r);
      end
      default: begin
        if (b == DLE) begin
          take_payload(b, hit, r);
        end else if (b == STX) begin
          start_frame();
        end else begin
          hit = 1'b1;
          if (b != ETX) r = status_of(ST_ESC_ERR);
          else if (!held_valid || payload_count == 0) r = status_of(ST_TOO_SHORT);
          else if (lrc_acc != 0) r = status_of(ST_LRC_ERR);
          else r = status_of(ST_OK);
          clear_frame();
          phase = PH_IDLE;
        end
      end
    endcase
    // buffer end overrides whatever this byte produced while a frame is open
    if (last) begin
      if (phase == PH_BODY || phase == PH_ESC) begin
        clear_frame();
        phase = PH_IDLE;
        hit   = 1'b1;
        r     = status_of(ST_NO_TRLR);
      end else if (phase == PH_HDR) begin
        phase = PH_IDLE;
        if (!hit) flag_junk(hit, r);
      end
      junk_reported = 1'b0;
    end
    if (hit) expected_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      max_payload = MAX_PAYLOAD_RST;
      clear_frame();
      phase         = PH_IDLE;
      junk_reported = 1'b0;
      expected_results.delete();
      fail_count    = 0;
      bytes_seen    = 0;
      payload_seen  = 0;
      status_count  = 0;
      status_seen   = '0;
      pending       = 0;
    end else begin
      if (cfg_valid && cfg_ready) max_payload = cfg_max_payload;
      if (out_valid && out_ready) begin
        if (out_kind == KIND_STATUS) begin
          status_count++;
          if (out_status < 7) status_seen[out_status] = 1'b1;
        end else begin
          payload_seen++;
        end
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result kind=%0d data=%02h status=%0d", $time,
                   out_kind, out_data, out_status);
        end else begin
          want = expected_results.pop_front();
          if (want.kind !== out_kind || want.data !== out_data ||
              want.status !== out_status) begin
            fail_count++;
            $display("%0t: mismatch expected %0d/%02h/%0d, actual %0d/%02h/%0d",
                     $time, want.kind, want.data, want.status,
                     out_kind, out_data, out_status);
          end
        end
      end
      if (in_valid && in_ready) begin
        bytes_seen++;
        deframe_byte(in_rx_byte, in_buffer_last);
      end
      pending = expected_results.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// top of the deframer testbench: clock, reset, framed and noisy byte traffic with
// bursty pacing, result back-pressure, max_payload settings and the verdict
// depends on dled_pkg, the channel interfaces, dle_stx_etx_deframer_lrc_unit, dled_check
module testbench;
  import dled_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 8;
  localparam int RANDOM_BYTES = 1500;
  localparam int NUM_SETTINGS = 7;

  typedef enum int {
    FLAW_NONE, FLAW_BAD_LRC, FLAW_BAD_ESCAPE, FLAW_RESTART, FLAW_CUT, FLAW_JUNK_LEAD
  } flaw_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       rx_ready = 1'b0;
  int         stall_mode = 0;
  int         stall_left = 0;
  int         burst_left = 0;
  int         sent_count = 0;
  int         cycle_count = 0;
  logic [7:0] raw_q[$];

  int         fail_count;
  int         pending;
  int         bytes_seen;
  int         payload_seen;
  int         status_count;
  logic [6:0] status_seen;

  dled_in_if  in_ch();
  dled_out_if out_ch();
  dled_cfg_if cfg_ch();

  assign out_ch.ready = rx_ready;

  dle_stx_etx_deframer_lrc_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  dled_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_rx_byte      (in_ch.rx_byte),
    .in_buffer_last  (in_ch.buffer_last),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.kind),
    .out_data        (out_ch.data),
    .out_status      (out_ch.status),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_max_payload (cfg_ch.max_payload),
    .fail_count      (fail_count),
    .pending         (pending),
    .bytes_seen      (bytes_seen),
    .payload_seen    (payload_seen),
    .status_count    (status_count),
    .status_seen     (status_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls: always ready, mostly ready, mostly stalled, or a fixed on/off beat
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rx_ready <= 1'b1;
      1: rx_ready <= ($urandom_range(0, 3) != 0);
      2: rx_ready <= ($urandom_range(0, 3) == 0);
      default: rx_ready <= stall_left[2];
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0, 1: return DLE;
      2: return STX;
      3: return ETX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_stuffed(input logic [7:0] v);
    if (v == DLE) raw_q.push_back(DLE);
    raw_q.push_back(v);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.rx_byte     <= b;
    in_ch.buffer_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    sent_count++;
  endtask

  task automatic send_raw(input logic buf_end);
    foreach (raw_q[i]) send_byte(raw_q[i], buf_end && i == raw_q.size() - 1);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [CFG_W-1:0] v);
    wait_idle();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.max_payload <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_frame(input int len, input flaw_t flaw, input logic buf_end);
    logic [7:0] lrc;
    logic [7:0] v;
    raw_q.delete();
    lrc = '0;
    if (flaw == FLAW_JUNK_LEAD) repeat ($urandom_range(1, 3)) raw_q.push_back(pick_byte());
    raw_q.push_back(DLE);
    raw_q.push_back(STX);
    for (int i = 0; i < len; i++) begin
      if (flaw == FLAW_RESTART && i == len / 2) begin
        raw_q.push_back(DLE);
        raw_q.push_back(STX);
        lrc = '0;
      end
      v = pick_byte();
      lrc = lrc ^ v;
      push_stuffed(v);
    end
    if (flaw == FLAW_BAD_LRC) lrc = lrc ^ (8'h01 << $urandom_range(0, 7));
    push_stuffed(lrc);
    case (flaw)
      FLAW_BAD_ESCAPE: begin
        do v = 8'($urandom_range(0, 255)); while (v == DLE || v == STX || v == ETX);
        raw_q.push_back(DLE);
        raw_q.push_back(v);
      end
      FLAW_CUT: repeat ($urandom_range(0, raw_q.size() - 3)) void'(raw_q.pop_back());
      default: begin
        raw_q.push_back(DLE);
        raw_q.push_back(ETX);
      end
    endcase
    send_raw(buf_end || flaw == FLAW_CUT);
  endtask

  initial begin
    logic [CFG_W-1:0] plan [NUM_SETTINGS];
    flaw_t            flaw;
    int               len;
    int               phase_end;
    plan = '{12'd256, 12'd0, 12'd1, 12'd4095, 12'd3, 12'd20, 12'd256};
    plan[5] = CFG_W'($urandom_range(2, 40));
    in_ch.valid        <= 1'b0;
    in_ch.rx_byte      <= '0;
    in_ch.buffer_last  <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.max_payload <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_max_payload(plan[0]);

    // junk, dle dle outside a frame, stuffed dle, too short, bad escape, restart + lrc error
    raw_q = '{8'hFF, DLE, DLE, STX, DLE, DLE, DLE, DLE, DLE, ETX,
              DLE, STX, 8'h55, DLE, ETX,
              DLE, STX, DLE, 8'h07,
              DLE, STX, 8'hAA, DLE, STX, 8'h01, 8'h00, DLE, ETX};
    send_raw(1'b0);
    // buffer end inside a frame, then after a lone header dle
    raw_q = '{DLE, STX, 8'h33};
    send_raw(1'b1);
    raw_q = '{DLE};
    send_raw(1'b1);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p > 0) write_max_payload(plan[p]);
      phase_end = sent_count + RANDOM_BYTES / NUM_SETTINGS;
      while (sent_count < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          raw_q.delete();
          repeat ($urandom_range(1, 6)) raw_q.push_back(pick_byte());
          send_raw($urandom_range(0, 2) == 0);
        end else begin
          if (plan[p] <= 40 && $urandom_range(0, 3) == 0)
            len = $urandom_range(plan[p] + 2, (plan[p] == 0) ? 0 : plan[p] - 1);
          else
            len = $urandom_range(0, 8);
          case ($urandom_range(0, 9))
            0: flaw = FLAW_BAD_LRC;
            1: flaw = FLAW_BAD_ESCAPE;
            2: flaw = FLAW_RESTART;
            3: flaw = FLAW_CUT;
            4: flaw = FLAW_JUNK_LEAD;
            default: flaw = FLAW_NONE;
          endcase
          send_frame(len, flaw, $urandom_range(0, 3) == 0);
        end
      end
    end

    wait_idle();
    $display("covered %0d bytes over %0d max_payload settings from 0 to 4095",
             bytes_seen, NUM_SETTINGS);
    $display("checked %0d payload bytes and %0d frame statuses, status codes seen %b",
             payload_seen, status_count, status_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
